### design/aes128_key_expansion_defines.svh
// ============================================================================
// aes128_key_expansion_defines.svh
// assertion macros shared by the key expansion checker
// ============================================================================
`ifndef AES128_KEY_EXPANSION_DEFINES_SVH
`define AES128_KEY_EXPANSION_DEFINES_SVH

// same-cycle implication, reset masked
`define KX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define KX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/aes_kx_pkg.sv
// ============================================================================
// aes_kx_pkg
// shared constants, types and tables of the aes-128 key expansion
// ============================================================================
package aes_kx_pkg;

    localparam int unsigned KEY_W        = 128;
    localparam int unsigned HALF_W       = 64;
    localparam int unsigned WORD_W       = 32;
    localparam int unsigned ROUND_W      = 4;
    localparam int unsigned RCON_COUNT   = 10;
    localparam int unsigned NUM_ROUNDS_DEF = 10;
    // round key halves plus round number, padded to whole bytes
    localparam int unsigned OUT_DATA_W   = 136;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ROUND_W-1:0] round_t;

    // controller to datapath commands
    typedef struct packed {
        logic   load;     // take a new cipher key
        logic   step;     // derive the next round key
        round_t rc_idx;   // round constant index for this step
    } kx_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // round constant byte, index 0 gives the constant of round 1
    function automatic logic [7:0] rcon(input round_t idx);
        logic [7:0] rc;
        case (idx)
            4'd0:    rc = 8'h01;
            4'd1:    rc = 8'h02;
            4'd2:    rc = 8'h04;
            4'd3:    rc = 8'h08;
            4'd4:    rc = 8'h10;
            4'd5:    rc = 8'h20;
            4'd6:    rc = 8'h40;
            4'd7:    rc = 8'h80;
            4'd8:    rc = 8'h1b;
            4'd9:    rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // rotate left one byte, then substitute each byte
    function automatic word_t sub_rot_word(input word_t w);
        word_t r;
        r = {w[23:0], w[31:24]};
        return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

endpackage

### design/aes_kx_ctrl.sv
// ============================================================================
// aes_kx_ctrl
// run controller: handshakes, round counter and datapath commands
// ============================================================================
module aes_kx_ctrl #(
    parameter int unsigned NUM_ROUNDS = aes_kx_pkg::NUM_ROUNDS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_last,
    output aes_kx_pkg::round_t      round_num,
    output aes_kx_pkg::kx_cmd_t     cmd
);
    import aes_kx_pkg::*;

    // rounds are capped by the length of the round constant table
    localparam int unsigned ROUNDS = (NUM_ROUNDS > RCON_COUNT) ? RCON_COUNT : NUM_ROUNDS;
    localparam round_t LAST_ROUND = ROUND_W'(ROUNDS);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    round_t round_reg;
    logic   is_last;

    assign is_last   = (round_reg == LAST_ROUND);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RUN);
    assign out_last  = is_last;
    assign round_num = round_reg;

    assign cmd.load   = in_valid & in_ready;
    assign cmd.step   = out_valid & out_ready & ~is_last;
    assign cmd.rc_idx = round_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_RUN;
                        round_reg <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (out_ready)
                    begin
                        if (is_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            round_reg <= round_reg + round_t'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    round_reg <= '0;
                end
            endcase
        end
    end

endmodule

### design/aes_kx_dp.sv
// ============================================================================
// aes_kx_dp
// round key register and one round of the key schedule
// ============================================================================
module aes_kx_dp (
    input  logic                          clk,
    input  aes_kx_pkg::kx_cmd_t           cmd,
    input  logic [aes_kx_pkg::KEY_W-1:0]  key_in,
    output logic [aes_kx_pkg::KEY_W-1:0]  round_key
);
    import aes_kx_pkg::*;

    word_t w_reg [4];
    word_t w_next [4];
    word_t t;

    // key_in: key_hi in the low half, word 0 on top of it
    always_comb
    begin
        t = sub_rot_word(w_reg[3]) ^ {rcon(cmd.rc_idx), 24'h000000};
        w_next[0] = w_reg[0] ^ t;
        w_next[1] = w_reg[1] ^ w_next[0];
        w_next[2] = w_reg[2] ^ w_next[1];
        w_next[3] = w_reg[3] ^ w_next[2];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg[0] <= key_in[63:32];
            w_reg[1] <= key_in[31:0];
            w_reg[2] <= key_in[127:96];
            w_reg[3] <= key_in[95:64];
        end
        else if (cmd.step)
        begin
            w_reg <= w_next;
        end
    end

    assign round_key = {w_reg[2], w_reg[3], w_reg[0], w_reg[1]};

endmodule

### design/aes128_key_expansion.sv
// ============================================================================
// aes128_key_expansion
// aes-128 key schedule: one cipher key in, the round keys out one by one
// ============================================================================
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | tdata: key_lo, key_hi
//  m_axis   | out       | tdata: zero pad, round_number, round_key_lo, round_key_hi
//           |           | tlast: last_key
//
//  a request on s_axis yields min(NUM_ROUNDS, 10) + 1 round keys, round 0 being the key
//  one round key per cycle while m_axis_tready is high: the round unit derives
//  the next key from the key register as the current one is taken
//  a new key is taken only after the last round key of the run has been taken;
//  s_axis_tready is high only between runs
//  a stall on m_axis simply holds the current round key in place
//  rst_n clears the controller; the key register is not reset
//
module aes128_key_expansion #(
    parameter int unsigned NUM_ROUNDS = aes_kx_pkg::NUM_ROUNDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input key request
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [aes_kx_pkg::KEY_W-1:0]       s_axis_tdata,  // key_lo, key_hi
    // round key output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // zero pad, round_number, round_key_lo, round_key_hi
    output logic [aes_kx_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                               m_axis_tlast   // last_key
);
    import aes_kx_pkg::*;

    kx_cmd_t             cmd;
    round_t              round_num;
    logic [KEY_W-1:0]    round_key;

    // sequencing and handshakes
    aes_kx_ctrl #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .round_num (round_num),
        .cmd       (cmd)
    );

    // key register and round function
    aes_kx_dp u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .key_in    (s_axis_tdata),
        .round_key (round_key)
    );

    // pad up to whole bytes above the round number
    assign m_axis_tdata = {{(OUT_DATA_W - KEY_W - ROUND_W){1'b0}}, round_num, round_key};

endmodule

### design/aes_kx_checker.sv
// ============================================================================
// aes_kx_checker
// port-level checks of the key expansion, bound to the top level
// ============================================================================
`include "aes128_key_expansion_defines.svh"

module aes_kx_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic [aes_kx_pkg::KEY_W-1:0]       s_axis_tdata,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [aes_kx_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                               m_axis_tlast
);
    import aes_kx_pkg::*;

    // a stalled round key stays offered
    `KX_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "round key dropped while stalled")

    // no new key while a run is in progress
    `KX_ASSERT_SAME(a_one_run, clk, rst_n, m_axis_tvalid, !s_axis_tready, "key request taken during a run")

    // round 0 is the key itself
    `KX_ASSERT_NEXT(a_round0, clk, rst_n, s_axis_tvalid && s_axis_tready, m_axis_tvalid && (m_axis_tdata[131:128] == 4'd0) && (m_axis_tdata[127:0] == $past(s_axis_tdata)), "round 0 differs from key")

    // round numbers count up by one
    `KX_ASSERT_NEXT(a_count, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tdata[131:128] == $past(m_axis_tdata[131:128]) + 4'd1), "round number skipped")

    // the run ends after the last round key
    `KX_ASSERT_NEXT(a_end, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "round key after the last one")

endmodule

bind aes128_key_expansion aes_kx_checker u_kx_checker (.*);
